// ===== sv/e2r_pkg.sv =====
`timescale 1ns / 1ps
package e2r_pkg;
	localparam int ANGLE_W = 17;
	localparam int OUT_W = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int Q = 30;
	localparam logic [31:0] RAD_PER_DEG = 32'd18740330;
	localparam int NSIN = 5;
	localparam int NCOS = 6;
	localparam int NSTEP = 6;

	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [OUT_W-1:0] entry_t;
	typedef logic signed [31:0] sq_t;   // signed Q30, |x| <= 2^30
	typedef logic [30:0] uq_t;          // magnitude Q30

	function automatic logic [7:0] sin_div(input int i);
		case (i)
			0: sin_div = 8'd110;
			1: sin_div = 8'd72;
			2: sin_div = 8'd42;
			3: sin_div = 8'd20;
			default: sin_div = 8'd6;
		endcase
	endfunction

	function automatic logic [7:0] cos_div(input int i);
		case (i)
			0: cos_div = 8'd132;
			1: cos_div = 8'd90;
			2: cos_div = 8'd56;
			3: cos_div = 8'd30;
			4: cos_div = 8'd12;
			default: cos_div = 8'd2;
		endcase
	endfunction

	// floor(2^32 / n) + 1 for each divisor
	function automatic logic [31:0] sin_rcp(input int i);
		case (i)
			0: sin_rcp = 32'd39045158;
			1: sin_rcp = 32'd59652324;
			2: sin_rcp = 32'd102261127;
			3: sin_rcp = 32'd214748365;
			default: sin_rcp = 32'd715827883;
		endcase
	endfunction

	function automatic logic [31:0] cos_rcp(input int i);
		case (i)
			0: cos_rcp = 32'd32537632;
			1: cos_rcp = 32'd47721859;
			2: cos_rcp = 32'd76695845;
			3: cos_rcp = 32'd143165577;
			4: cos_rcp = 32'd357913942;
			default: cos_rcp = 32'd2147483649;
		endcase
	endfunction

	// floor(x / d) for x < 2^31 via (x*r)>>32, then one correction
	function automatic logic [30:0] div_const(input logic [30:0] x, input logic [7:0] d,
			input logic [31:0] r);
		logic [62:0] p;
		logic [30:0] qv;
		logic [38:0] back;
		p = 63'(x) * 63'(r);
		qv = 31'(p >> 32);
		back = 39'(qv) * 39'(d);
		if (39'(x) < back) qv = qv - 31'd1;
		div_const = qv;
	endfunction

	function automatic sq_t smul(input sq_t p, input sq_t q);
		logic neg;
		logic [31:0] mp, mq;
		logic [63:0] pr;
		logic [31:0] r;
		neg = p[31] ^ q[31];
		mp = p[31] ? 32'(-p) : 32'(p);
		mq = q[31] ? 32'(-q) : 32'(q);
		pr = 64'(mp) * 64'(mq) + (64'd1 << 29);
		r = 32'(pr >> 30);
		smul = neg ? sq_t'(-r) : sq_t'(r);
	endfunction
endpackage

// ===== sv/e2r_sincos.sv =====
`timescale 1ns / 1ps
module e2r_sincos #(
	parameter int ANGLE_FRAC_BITS = e2r_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input e2r_pkg::angle_t angle,
	output e2r_pkg::sq_t sin_o,
	output e2r_pkg::sq_t cos_o
);
	import e2r_pkg::*;
	localparam int FULL = 360 << ANGLE_FRAC_BITS;
	localparam int QUART = 90 << ANGLE_FRAC_BITS;
	localparam int EIGHTH = 45 << ANGLE_FRAC_BITS;
	localparam int MW = 32;
	// multiple of FULL that keeps -angle non-negative
	localparam int OFS = FULL * ((65536 + FULL - 1) / FULL);
	localparam longint RCP = (64'sd1 <<< 32) / FULL;
	localparam logic [30:0] ONE = 31'(1 << Q);

	logic signed [MW-1:0] v_c;
	logic [MW-1:0] x_c;
	logic [63:0] qm_c;
	assign v_c = MW'(signed'(angle));
	assign x_c = MW'(OFS - v_c);
	assign qm_c = 64'(x_c) * 64'(RCP);

	// quotient estimate is exact or one low
	logic [MW-1:0] x_s1, qd_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_c;
			qd_s1 <= 32'(qm_c >> 32);
		end
	end

	logic [MW-1:0] m_c;
	logic [MW-1:0] m_s2;
	assign m_c = x_s1 - qd_s1 * MW'(FULL);
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= (m_c >= MW'(FULL)) ? m_c - MW'(FULL) : m_c;
		end
	end

	logic [1:0] q_c;
	logic [MW-1:0] u_c;
	logic swap_c;
	always_comb begin
		if (m_s2 >= MW'(3 * QUART)) begin
			q_c = 2'd3;
			u_c = m_s2 - MW'(3 * QUART);
		end else if (m_s2 >= MW'(2 * QUART)) begin
			q_c = 2'd2;
			u_c = m_s2 - MW'(2 * QUART);
		end else if (m_s2 >= MW'(QUART)) begin
			q_c = 2'd1;
			u_c = m_s2 - MW'(QUART);
		end else begin
			q_c = 2'd0;
			u_c = m_s2;
		end
		swap_c = u_c > MW'(EIGHTH);
	end

	logic [MW-1:0] u_s3;
	logic swap_s3;
	logic [1:0] q_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			swap_s3 <= swap_c;
			u_s3 <= swap_c ? MW'(QUART) - u_c : u_c;
			q_s3 <= q_c;
		end
	end

	logic [30:0] t_s4;
	logic swap_s4;
	logic [1:0] q_s4;
	logic [63:0] tm;
	assign tm = 64'(u_s3) * 64'(RAD_PER_DEG);
	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= 31'(tm >> ANGLE_FRAC_BITS);
			swap_s4 <= swap_s3;
			q_s4 <= q_s3;
		end
	end

	logic [30:0] t2_s5, t_s5;
	logic swap_s5;
	logic [1:0] q_s5;
	logic [61:0] t2m;
	assign t2m = 62'(t_s4) * 62'(t_s4);
	always_ff @(posedge clk) begin
		if (en) begin
			t2_s5 <= 31'(t2m >> Q);
			t_s5 <= t_s4;
			swap_s5 <= swap_s4;
			q_s5 <= q_s4;
		end
	end

	// Horner lanes: each step is a multiply stage then a divide stage
	logic [30:0] ps_q [1:NSTEP];
	logic [30:0] pc_q [1:NSTEP];
	logic [30:0] t2_q [1:NSTEP];
	logic [30:0] tt_q [1:NSTEP];
	logic swap_q [1:NSTEP];
	logic [1:0] qq_q [1:NSTEP];

	for (genvar g = 0; g < NSTEP; g++) begin : g_step
		logic [30:0] ps_i, pc_i, t2_i, tt_i;
		logic swap_i;
		logic [1:0] qq_i;
		logic [61:0] ms, mc;
		logic [30:0] ms_q, mc_q, ps_h_q, t2_h_q, tt_h_q;
		logic swap_h_q;
		logic [1:0] qq_h_q;
		logic [30:0] ps_n, pc_n;

		if (g == 0) begin : g_first
			assign ps_i = ONE;
			assign pc_i = ONE;
			assign t2_i = t2_s5;
			assign tt_i = t_s5;
			assign swap_i = swap_s5;
			assign qq_i = q_s5;
		end else begin : g_next
			assign ps_i = ps_q[g];
			assign pc_i = pc_q[g];
			assign t2_i = t2_q[g];
			assign tt_i = tt_q[g];
			assign swap_i = swap_q[g];
			assign qq_i = qq_q[g];
		end

		assign ms = 62'(t2_i) * 62'(ps_i);
		assign mc = 62'(t2_i) * 62'(pc_i);
		always_ff @(posedge clk) begin
			if (en) begin
				ms_q <= 31'(ms >> Q);
				mc_q <= 31'(mc >> Q);
				ps_h_q <= ps_i;
				t2_h_q <= t2_i;
				tt_h_q <= tt_i;
				swap_h_q <= swap_i;
				qq_h_q <= qq_i;
			end
		end

		always_comb begin
			pc_n = ONE - div_const(mc_q, cos_div(g), cos_rcp(g));
			if (g < NSIN)
				ps_n = ONE - div_const(ms_q, sin_div(g), sin_rcp(g));
			else
				ps_n = ps_h_q;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ps_q[g+1] <= ps_n;
				pc_q[g+1] <= pc_n;
				t2_q[g+1] <= t2_h_q;
				tt_q[g+1] <= tt_h_q;
				swap_q[g+1] <= swap_h_q;
				qq_q[g+1] <= qq_h_q;
			end
		end
	end

	logic [61:0] sm;
	logic [30:0] s0, c0;
	logic signed [31:0] so, co;
	always_comb begin
		sm = 62'(tt_q[NSTEP]) * 62'(ps_q[NSTEP]);
		s0 = swap_q[NSTEP] ? pc_q[NSTEP] : 31'(sm >> Q);
		c0 = swap_q[NSTEP] ? 31'(sm >> Q) : pc_q[NSTEP];
		case (qq_q[NSTEP])
			2'd0: begin so = 32'(s0); co = 32'(c0); end
			2'd1: begin so = 32'(c0); co = -32'(s0); end
			2'd2: begin so = -32'(s0); co = -32'(c0); end
			default: begin so = -32'(c0); co = 32'(s0); end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= so;
			cos_o <= co;
		end
	end
endmodule

// ===== sv/e2r_merge.sv =====
`timescale 1ns / 1ps
module e2r_merge #(
	parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input e2r_pkg::sq_t sx, cx, sy, cy, sz, cz,
	output e2r_pkg::entry_t r [9]
);
	import e2r_pkg::*;
	localparam int SH = Q - OUT_FRAC_BITS;

	function automatic entry_t to_out(input logic signed [33:0] x);
		logic neg;
		logic [33:0] mag;
		neg = x[33];
		mag = neg ? 34'(-x) : 34'(x);
		if (SH > 0) mag = (mag + (34'd1 << (SH - 1))) >> SH;
		if (mag > (34'd1 << OUT_FRAC_BITS)) mag = 34'd1 << OUT_FRAC_BITS;
		to_out = neg ? entry_t'(-mag) : entry_t'(mag);
	endfunction

	sq_t a00_s1, a02_s1, a10_s1, a11_s1, a12_s1, a20_s1, a21_s1, a22_s1, sz_s1, cz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a00_s1 <= cy;
			a02_s1 <= sy;
			a10_s1 <= smul(sx, sy);
			a11_s1 <= cx;
			a12_s1 <= -smul(sx, cy);
			a20_s1 <= -smul(cx, sy);
			a21_s1 <= sx;
			a22_s1 <= smul(cx, cy);
			sz_s1 <= sz;
			cz_s1 <= cz;
		end
	end

	sq_t p [12];
	sq_t d0_s2, d1_s2, d2_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p[0] <= smul(a00_s1, cz_s1);
			p[1] <= 32'sd0;
			p[2] <= 32'sd0;
			p[3] <= smul(a00_s1, sz_s1);
			p[4] <= smul(a10_s1, cz_s1);
			p[5] <= smul(a11_s1, sz_s1);
			p[6] <= smul(a11_s1, cz_s1);
			p[7] <= smul(a10_s1, sz_s1);
			p[8] <= smul(a20_s1, cz_s1);
			p[9] <= smul(a21_s1, sz_s1);
			p[10] <= smul(a21_s1, cz_s1);
			p[11] <= smul(a20_s1, sz_s1);
			d0_s2 <= a02_s1;
			d1_s2 <= a12_s1;
			d2_s2 <= a22_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r[0] <= to_out(34'(p[0]) + 34'(p[1]));
			r[1] <= to_out(34'(p[2]) - 34'(p[3]));
			r[2] <= to_out(34'(d0_s2));
			r[3] <= to_out(34'(p[4]) + 34'(p[5]));
			r[4] <= to_out(34'(p[6]) - 34'(p[7]));
			r[5] <= to_out(34'(d1_s2));
			r[6] <= to_out(34'(p[8]) + 34'(p[9]));
			r[7] <= to_out(34'(p[10]) - 34'(p[11]));
			r[8] <= to_out(34'(d2_s2));
		end
	end
endmodule

// ===== sv/euler_to_rotation_matrix_unit.sv =====
`timescale 1ns / 1ps
// An accepted beat passes the sin/cos lanes, then the merge, to output.
// Throughput: one beat per cycle; the whole pipeline advances when the
// output is free or empty, so stall stops everything in lockstep.
// Reset: arst_n clears only the stage valid bits; no other state.
module euler_to_rotation_matrix_unit #(
	parameter int ANGLE_FRAC_BITS = e2r_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = e2r_pkg::OUT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input e2r_pkg::angle_t roll_angle,
	input e2r_pkg::angle_t pitch_angle,
	input e2r_pkg::angle_t yaw_angle,
	output logic out_valid,
	input logic out_stall,
	output e2r_pkg::entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22
);
	import e2r_pkg::*;
	localparam int LAT = 2 * NSTEP + 9;

	logic en;
	logic [LAT-1:0] vld_q;
	sq_t s [3];
	sq_t c [3];
	entry_t r [9];
	angle_t ang [3];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];
	assign ang[0] = roll_angle;
	assign ang[1] = pitch_angle;
	assign ang[2] = yaw_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc (
			.clk(clk), .en(en), .angle(ang[g]),
			.sin_o(s[g]), .cos_o(c[g])
		);
	end

	e2r_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
		.clk(clk), .en(en),
		.sx(s[0]), .cx(c[0]), .sy(s[1]), .cy(c[1]), .sz(s[2]), .cz(c[2]),
		.r(r)
	);

	assign r00 = r[0];
	assign r01 = r[1];
	assign r02 = r[2];
	assign r10 = r[3];
	assign r11 = r[4];
	assign r12 = r[5];
	assign r20 = r[6];
	assign r21 = r[7];
	assign r22 = r[8];
endmodule

// ===== sim/euler_to_rotation_matrix_unit_tb.sv =====
`timescale 1ns / 1ps
module euler_to_rotation_matrix_unit_tb;
	import e2r_pkg::*;

	typedef struct {
		logic [15:0] e [9];
	} matrix_t;

	function automatic longint mul_q30(longint p, longint q);
		return (p * q) >>> 30;
	endfunction

	function automatic longint mul_round(longint p, longint q);
		bit neg;
		longint mp, mq, r;
		neg = (p < 0) != (q < 0);
		mp = p < 0 ? -p : p;
		mq = q < 0 ? -q : q;
		r = (mp * mq + (64'sd1 <<< 29)) >>> 30;
		return neg ? -r : r;
	endfunction

	task automatic first_octant(input longint u, output longint s, output longint c);
		longint t, t2, p;
		int sd [5];
		int cd [6];
		sd = '{110, 72, 42, 20, 6};
		cd = '{132, 90, 56, 30, 12, 2};
		t = (u * 18740330) >>> 7;
		t2 = mul_q30(t, t);
		p = 64'sd1 <<< 30;
		foreach (sd[i]) p = (64'sd1 <<< 30) - mul_q30(t2, p) / sd[i];
		s = mul_q30(t, p);
		p = 64'sd1 <<< 30;
		foreach (cd[i]) p = (64'sd1 <<< 30) - mul_q30(t2, p) / cd[i];
		c = p;
	endtask

	task automatic angle_sincos(input logic [16:0] a, output longint s, output longint c);
		longint v, m, u, q, s0, c0;
		v = longint'($signed(a));
		m = (-v) % 46080;
		if (m < 0) m += 46080;
		q = m / 11520;
		u = m - q * 11520;
		if (u <= 5760) first_octant(u, s0, c0);
		else first_octant(11520 - u, c0, s0);
		case (q)
			0: begin s = s0; c = c0; end
			1: begin s = c0; c = -s0; end
			2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endtask

	function automatic logic [15:0] to_entry(longint x);
		bit neg;
		longint mag;
		neg = x < 0;
		mag = neg ? -x : x;
		mag = (mag + (1 << 15)) >>> 16;
		if (mag > 16384) mag = 16384;
		return 16'(neg ? -mag : mag);
	endfunction

	task automatic rotation_of(input logic [16:0] ra, pa, ya, output matrix_t m);
		longint sx, cx, sy, cy, sz, cz;
		longint a [3][3];
		longint r [9];
		angle_sincos(ra, sx, cx);
		angle_sincos(pa, sy, cy);
		angle_sincos(ya, sz, cz);
		a[0][0] = cy; a[0][1] = 0; a[0][2] = sy;
		a[1][0] = mul_round(sx, sy); a[1][1] = cx; a[1][2] = -mul_round(sx, cy);
		a[2][0] = -mul_round(cx, sy); a[2][1] = sx; a[2][2] = mul_round(cx, cy);
		for (int i = 0; i < 3; i++) begin
			r[i*3] = mul_round(a[i][0], cz) + mul_round(a[i][1], sz);
			r[i*3+1] = mul_round(a[i][1], cz) - mul_round(a[i][0], sz);
			r[i*3+2] = a[i][2];
		end
		foreach (r[i]) m.e[i] = to_entry(r[i]);
	endtask

	class matrix_board;
		matrix_t pending [$];
		int errors;
		int checked;
		string names [9];

		function new();
			names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
		endfunction

		task note_angles(input logic [16:0] ra, pa, ya);
			matrix_t m;
			rotation_of(ra, pa, ya, m);
			pending.push_back(m);
		endtask

		function void check_matrix(matrix_t got);
			matrix_t want;
			if (pending.size() == 0) begin
				$error("result beat with no pending matrix");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			foreach (got.e[i])
				if (got.e[i] !== want.e[i]) begin
					$error("%s expected %h actual %h", names[i], want.e[i], got.e[i]);
					errors++;
				end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic [16:0] roll_angle = 0, pitch_angle = 0, yaw_angle = 0;
	logic in_stall, out_valid;
	logic [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	matrix_board board = new();
	longint cycles = 0;
	int idle_pct = 16;
	bit hold_out = 0;

	euler_to_rotation_matrix_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		matrix_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.e = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			board.check_matrix(got);
		end
	end

	always @(negedge clk) begin
		if (hold_out) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic send_beat(input logic [16:0] ra, pa, ya);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		roll_angle <= ra;
		pitch_angle <= pa;
		yaw_angle <= ya;
		do @(posedge clk); while (in_stall);
		board.note_angles(ra, pa, ya);
		@(negedge clk);
	endtask

	function automatic logic [16:0] rand_angle();
		case ($urandom_range(9))
			0: return 17'($urandom);
			1: return 17'($signed($urandom_range(8)) * 5760 - 23040);
			default: return 17'($urandom_range(92160) - 46080);
		endcase
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		logic [16:0] edges [10];
		edges = '{17'h00000, 17'h0FFFF, 17'h10000, 17'h1FFFF, 17'd46080,
			-17'sd46080, 17'd11520, 17'd5760, 17'd5761, 17'd23040};
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			send_beat(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
		for (int i = 0; i < 8; i++)
			send_beat(17'(i * 5760), 17'(-i * 5760), 17'(i * 2880 + 1));
		drain();
		fork
			begin
				hold_out = 1;
				repeat (60) @(negedge clk);
				hold_out = 0;
			end
			for (int i = 0; i < 40; i++) send_beat(rand_angle(), rand_angle(), rand_angle());
		join
		drain();
		for (int i = 0; i < 1800; i++) begin
			idle_pct = (i >= 600 && i < 900) ? 0 : 16;
			send_beat(rand_angle(), rand_angle(), rand_angle());
		end
		drain();
		$display("Checked %0d rotation matrices: edge angles, wraparound, octant", board.checked);
		$display("boundaries, random triples, backpressure and idle gaps.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
